>>> rtl/blop_pkg.sv
// ----------------------------------------------------------------------------
// blop_pkg
// Constants and fixed-point helpers for the binomial lattice option pricer.
// ----------------------------------------------------------------------------
package blop_pkg;

    localparam int          MAX_STEPS_DEF = 256;
    localparam int          STEP_W        = 9;
    localparam logic [8:0]  STEP_RESET    = 9'd256;
    localparam logic [31:0] ONE_Q28       = 32'h1000_0000;

    // Drop 28 fraction bits of a 96-bit product, saturate to 64 bits.
    function automatic logic [63:0] sat_q28(input logic [95:0] a);
        logic [63:0] r;
        if (a[95:92] != 4'd0) begin
            r = '1;
        end else begin
            r = a[91:28];
        end
        return r;
    endfunction

    // Drop 30 fraction bits of a 96-bit sum, saturate to 64 bits.
    function automatic logic [63:0] sat_q30(input logic [95:0] a);
        logic [63:0] r;
        if (a[95:94] != 2'd0) begin
            r = '1;
        end else begin
            r = a[93:30];
        end
        return r;
    endfunction

    // Drop 28 fraction bits of a 64-bit product, saturate to 32 bits.
    function automatic logic [31:0] sat_factor(input logic [63:0] a);
        logic [31:0] r;
        if (a[63:60] != 4'd0) begin
            r = '1;
        end else begin
            r = a[59:28];
        end
        return r;
    endfunction

    // Call or put payoff, floored at zero.
    function automatic logic [63:0] payoff(input logic [63:0] spot,
                                           input logic [63:0] strike,
                                           input logic        call);
        logic [63:0] r;
        r = 64'd0;
        if (call) begin
            if (spot > strike) r = spot - strike;
        end else begin
            if (strike > spot) r = strike - spot;
        end
        return r;
    endfunction

endpackage

>>> rtl/binomial_lattice_option_pricer.sv
// Throughput: one word at a time; the next input word is taken once the result
//   sits in the output register. One shared 32x32 multiplier sets the pace.
// Reset: synchronous active-low; clears the sequencer and output valid, and
//   sets the step count to 256. The node and spot memories are not cleared.
// ----------------------------------------------------------------------------
// binomial_lattice_option_pricer
// CRR binomial lattice pricer: terminal spots and payoffs, then backward
// induction over one rolling vector of node values held in RAM.
// ----------------------------------------------------------------------------
module binomial_lattice_option_pricer #(
    parameter int MAX_STEPS = blop_pkg::MAX_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [blop_pkg::STEP_W-1:0] i_cfg_step_count,
    // input word
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [63:0]                 i_lowest_spot,
    input  logic [31:0]                 i_up_squared,
    input  logic [31:0]                 i_up_factor,
    input  logic [30:0]                 i_weight_up,
    input  logic [30:0]                 i_weight_down,
    input  logic [63:0]                 i_strike,
    input  logic                        i_is_call,
    input  logic                        i_is_american,
    // result word
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_price,
    output logic [63:0]                 o_layer1_down,
    output logic [63:0]                 o_layer1_up,
    output logic [63:0]                 o_layer2_down_down,
    output logic [63:0]                 o_layer2_middle,
    output logic [63:0]                 o_layer2_up_up,
    output logic                        o_layers_valid
);

    import blop_pkg::*;

    localparam int DEPTH = MAX_STEPS + 1;
    localparam int AW    = $clog2(DEPTH);

    // Micro-step numbers inside each state.
    localparam logic [3:0] PH_0  = 4'd0;
    localparam logic [3:0] PH_1  = 4'd1;
    localparam logic [3:0] PH_2  = 4'd2;
    localparam logic [3:0] PH_3  = 4'd3;
    localparam logic [3:0] PH_4  = 4'd4;
    localparam logic [3:0] PH_5  = 4'd5;
    localparam logic [3:0] PH_6  = 4'd6;
    localparam logic [3:0] PH_7  = 4'd7;
    localparam logic [3:0] PH_8  = 4'd8;
    localparam logic [3:0] PH_9  = 4'd9;
    localparam logic [3:0] PH_10 = 4'd10;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TERM  = 5'b00010,   // terminal spots and payoffs
        S_LEVEL = 5'b00100,   // per-level set-up: level factor, first node
        S_NODE  = 5'b01000,   // one node update per pass
        S_OUT   = 5'b10000    // hand result to the output register
    } t_state;

    t_state        r_state;
    logic [3:0]    r_ph;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_lev;
    logic [AW-1:0] r_n;
    logic [8:0]    r_step_count;
    logic [31:0]   r_lf;
    logic          r_o_valid;

    // item operands
    logic [63:0] r_spot;
    logic [31:0] r_u2;
    logic [31:0] r_u;
    logic [30:0] r_wu;
    logic [30:0] r_wd;
    logic [63:0] r_k;
    logic        r_call;
    logic        r_amer;

    // arithmetic
    logic [63:0] r_prod;
    logic [95:0] r_acc;
    logic [63:0] r_vup;
    logic [63:0] r_vdn;
    logic [63:0] r_ts;
    logic [63:0] r_cont;

    // captured layers
    logic [63:0] r_price;
    logic [63:0] r_l1 [2];
    logic [63:0] r_l2 [3];

    // output register
    logic [63:0] r_o_price;
    logic [63:0] r_o_l1d;
    logic [63:0] r_o_l1u;
    logic [63:0] r_o_l2dd;
    logic [63:0] r_o_l2m;
    logic [63:0] r_o_l2uu;
    logic        r_o_lv;

    logic          w_accept;
    logic          w_load;
    logic [31:0]   w_n32;
    logic [AW-1:0] w_n;
    logic [31:0]   w_ma;
    logic [31:0]   w_mb;
    logic [63:0]   w_prod;
    logic [63:0]   w_spot_new;
    logic [63:0]   w_ex;
    logic [63:0]   w_node;
    logic          w_cap_en;
    logic [AW-1:0] w_cap_lev;
    logic [AW-1:0] w_cap_idx;
    logic [63:0]   w_cap_val;

    // memory ports
    logic          w_nv_we;
    logic [AW-1:0] w_nv_waddr;
    logic [63:0]   w_nv_wdata;
    logic [AW-1:0] w_nv_raddr;
    logic [63:0]   w_nv_q;
    logic          w_ts_we;
    logic [63:0]   w_ts_wdata;
    logic [AW-1:0] w_ts_raddr;
    logic [63:0]   w_ts_q;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_OUT) && (!r_o_valid || i_ready);

    // Clamp the step count to the built lattice size.
    assign w_n32 = (32'(r_step_count) > 32'(MAX_STEPS)) ? 32'(MAX_STEPS)
                                                        : 32'(r_step_count);
    assign w_n   = w_n32[AW-1:0];

    // Shared multiplier: pick operand halves per micro-step.
    always_comb begin
        w_ma = r_spot[31:0];
        w_mb = r_u2;
        unique case (r_state)
            S_TERM: begin
                w_ma = (r_ph == PH_1) ? r_spot[63:32] : r_spot[31:0];
            end
            S_LEVEL: begin
                w_ma = r_lf;
                w_mb = r_u;
            end
            S_NODE: begin
                case (r_ph)
                    PH_2:    begin w_ma = r_vup[31:0];  w_mb = {1'b0, r_wu}; end
                    PH_3:    begin w_ma = r_vup[63:32]; w_mb = {1'b0, r_wu}; end
                    PH_4:    begin w_ma = r_vdn[31:0];  w_mb = {1'b0, r_wd}; end
                    PH_5:    begin w_ma = r_vdn[63:32]; w_mb = {1'b0, r_wd}; end
                    PH_7:    begin w_ma = r_ts[31:0];   w_mb = r_lf; end
                    PH_8:    begin w_ma = r_ts[63:32];  w_mb = r_lf; end
                    default: begin w_ma = r_ts[31:0];   w_mb = r_lf; end
                endcase
            end
            default: begin
                w_ma = r_spot[31:0];
                w_mb = r_u2;
            end
        endcase
    end

    assign w_prod     = w_ma * w_mb;
    assign w_spot_new = sat_q28(r_acc);
    assign w_ex       = payoff(sat_q28(r_acc), r_k, r_call);
    assign w_node     = (r_amer && (w_ex > r_cont)) ? w_ex : r_cont;

    // Memory writes: spot and payoff of node 0 on accept, then the terminal
    // layer, then each node update in place.
    always_comb begin
        w_nv_we    = 1'b0;
        w_nv_waddr = r_i;
        w_nv_wdata = w_node;
        w_ts_we    = 1'b0;
        w_ts_wdata = w_spot_new;
        w_cap_en   = 1'b0;
        w_cap_lev  = r_lev;
        w_cap_idx  = r_i;
        w_cap_val  = w_node;
        if (w_accept) begin
            w_nv_we    = 1'b1;
            w_nv_waddr = '0;
            w_nv_wdata = payoff(i_lowest_spot, i_strike, i_is_call);
            w_ts_we    = 1'b1;
            w_ts_wdata = i_lowest_spot;
            w_cap_en   = 1'b1;
            w_cap_lev  = w_n;
            w_cap_idx  = '0;
            w_cap_val  = w_nv_wdata;
        end else if ((r_state == S_TERM) && (r_ph == PH_3)) begin
            w_nv_we    = 1'b1;
            w_nv_wdata = payoff(w_spot_new, r_k, r_call);
            w_ts_we    = 1'b1;
            w_cap_en   = 1'b1;
            w_cap_val  = w_nv_wdata;
        end else if ((r_state == S_NODE) && (r_ph == PH_10)) begin
            w_nv_we    = 1'b1;
            w_cap_en   = 1'b1;
        end
    end

    // Read the upper neighbor while updating a node; node 0 at level start.
    assign w_nv_raddr = (r_state == S_NODE) ? AW'(r_i + 1'b1) : '0;
    assign w_ts_raddr = r_i;

    blop_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_nv_we),
        .i_waddr (w_nv_waddr),
        .i_wdata (w_nv_wdata),
        .i_raddr (w_nv_raddr),
        .o_rdata (w_nv_q)
    );

    blop_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_spot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ts_we),
        .i_waddr (w_nv_waddr),
        .i_wdata (w_ts_wdata),
        .i_raddr (w_ts_raddr),
        .o_rdata (w_ts_q)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ph         <= PH_0;
            r_i          <= '0;
            r_lev        <= '0;
            r_n          <= '0;
            r_step_count <= STEP_RESET;
            r_lf         <= ONE_Q28;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step_count <= i_cfg_step_count;
            end
            // Load a new result, or drop valid once the held one is taken.
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n     <= w_n;
                        r_lev   <= w_n;
                        r_i     <= AW'(1);
                        r_lf    <= ONE_Q28;
                        r_ph    <= PH_0;
                        r_state <= (w_n == '0) ? S_OUT : S_TERM;
                    end
                end
                S_TERM: begin
                    if (r_ph == PH_3) begin
                        r_ph <= PH_0;
                        if (r_i == r_n) begin
                            r_lev   <= r_lev - 1'b1;
                            r_state <= S_LEVEL;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_LEVEL: begin
                    if (r_ph == PH_1) begin
                        r_lf    <= sat_factor(r_prod);
                        r_ph    <= PH_0;
                        r_i     <= '0;
                        r_state <= S_NODE;
                    end else begin
                        r_ph <= PH_1;
                    end
                end
                S_NODE: begin
                    if (r_ph == PH_10) begin
                        r_ph <= PH_0;
                        if (r_i == r_lev) begin
                            if (r_lev == '0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_lev   <= r_lev - 1'b1;
                                r_state <= S_LEVEL;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_accept) begin
            r_spot <= i_lowest_spot;
            r_u2   <= i_up_squared;
            r_u    <= i_up_factor;
            r_wu   <= i_weight_up;
            r_wd   <= i_weight_down;
            r_k    <= i_strike;
            r_call <= i_is_call;
            r_amer <= i_is_american;
        end
        if (r_state == S_TERM) begin
            case (r_ph)
                PH_1:    r_acc  <= {32'd0, r_prod};
                PH_2:    r_acc  <= r_acc + {r_prod, 32'd0};
                PH_3:    r_spot <= w_spot_new;
                default: ;
            endcase
        end
        if ((r_state == S_LEVEL) && (r_ph == PH_1)) begin
            r_vdn <= w_nv_q;
        end
        if (r_state == S_NODE) begin
            case (r_ph)
                PH_1: begin
                    r_vup <= w_nv_q;
                    r_ts  <= w_ts_q;
                end
                PH_3:    r_acc  <= {32'd0, r_prod};
                PH_4:    r_acc  <= r_acc + {r_prod, 32'd0};
                PH_5:    r_acc  <= r_acc + {32'd0, r_prod};
                PH_6:    r_acc  <= r_acc + {r_prod, 32'd0};
                PH_7:    r_cont <= sat_q30(r_acc);
                PH_8:    r_acc  <= {32'd0, r_prod};
                PH_9:    r_acc  <= r_acc + {r_prod, 32'd0};
                PH_10:   r_vdn  <= r_vup;
                default: ;
            endcase
        end
        // Hold the root and the first two layers as they are written.
        if (w_cap_en) begin
            if ((w_cap_lev == '0) && (w_cap_idx == '0)) begin
                r_price <= w_cap_val;
            end
            if ((w_cap_lev == AW'(1)) && (w_cap_idx <= AW'(1))) begin
                r_l1[w_cap_idx[0]] <= w_cap_val;
            end
            if (w_cap_lev == AW'(2)) begin
                case (w_cap_idx)
                    AW'(0):  r_l2[0] <= w_cap_val;
                    AW'(1):  r_l2[1] <= w_cap_val;
                    AW'(2):  r_l2[2] <= w_cap_val;
                    default: ;
                endcase
            end
        end
        if (w_load) begin
            r_o_price <= r_price;
            r_o_lv    <= (r_n > AW'(1));
            r_o_l1d   <= (r_n > AW'(1)) ? r_l1[0] : 64'd0;
            r_o_l1u   <= (r_n > AW'(1)) ? r_l1[1] : 64'd0;
            r_o_l2dd  <= (r_n > AW'(1)) ? r_l2[0] : 64'd0;
            r_o_l2m   <= (r_n > AW'(1)) ? r_l2[1] : 64'd0;
            r_o_l2uu  <= (r_n > AW'(1)) ? r_l2[2] : 64'd0;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_price            = r_o_price;
    assign o_layer1_down      = r_o_l1d;
    assign o_layer1_up        = r_o_l1u;
    assign o_layer2_down_down = r_o_l2dd;
    assign o_layer2_middle    = r_o_l2m;
    assign o_layer2_up_up     = r_o_l2uu;
    assign o_layers_valid     = r_o_lv;

endmodule

>>> rtl/blop_ram.sv
// ----------------------------------------------------------------------------
// blop_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module blop_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/tb_binomial_lattice_option_pricer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_lattice_option_pricer
// Self-checking bench for the lattice pricer. A local fixed-point predictor
// prices every accepted word; a monitor compares each result word field by
// field against the oldest prediction. Directed corners come first, then
// random options over several step counts and idle/stall mixes, then one deep lattice.
// ----------------------------------------------------------------------------
module tb_binomial_lattice_option_pricer;
    import blop_pkg::*;

    typedef struct packed {
        logic [63:0] lowest_spot;
        logic [31:0] up_squared;
        logic [31:0] up_factor;
        logic [30:0] weight_up;
        logic [30:0] weight_down;
        logic [63:0] strike;
        logic        is_call;
        logic        is_american;
    } t_option;

    typedef struct packed {
        logic [63:0] price;
        logic [63:0] l1_down;
        logic [63:0] l1_up;
        logic [63:0] l2_dd;
        logic [63:0] l2_mid;
        logic [63:0] l2_uu;
        logic        layers_valid;
    } t_quote;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [STEP_W-1:0] i_cfg_step_count;
    logic i_valid;
    logic o_ready;
    t_option opt;
    logic o_valid;
    logic i_ready;
    wire t_quote got;

    binomial_lattice_option_pricer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_step_count  (i_cfg_step_count),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_lowest_spot     (opt.lowest_spot),
        .i_up_squared      (opt.up_squared),
        .i_up_factor       (opt.up_factor),
        .i_weight_up       (opt.weight_up),
        .i_weight_down     (opt.weight_down),
        .i_strike          (opt.strike),
        .i_is_call         (opt.is_call),
        .i_is_american     (opt.is_american),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_price           (got.price),
        .o_layer1_down     (got.l1_down),
        .o_layer1_up       (got.l1_up),
        .o_layer2_down_down(got.l2_dd),
        .o_layer2_middle   (got.l2_mid),
        .o_layer2_up_up    (got.l2_uu),
        .o_layers_valid    (got.layers_valid)
    );

    // Predictor state: its own copy of the step register and the lattice.
    logic [8:0]  model_steps;
    logic [63:0] model_nodes [0:256];
    logic [63:0] model_spots [0:256];

    t_quote pending_quotes[$];
    int     mismatch_count;
    int     words_sent;
    int     words_checked;
    int     send_idle_pct;
    int     recv_stall_pct;

    // Clock: 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(300_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // ---- fixed-point helpers (floor, saturate) ----
    function automatic logic [63:0] scale_q28(logic [63:0] a, logic [31:0] b);
        logic [95:0] prod;
        prod = {32'd0, a} * {64'd0, b};
        prod = prod >> 28;
        return (prod[95:64] != 0) ? {64{1'b1}} : prod[63:0];
    endfunction

    function automatic logic [63:0] discount_pair(logic [63:0] vup, logic [30:0] wu,
                                                  logic [63:0] vdn, logic [30:0] wd);
        logic [95:0] acc;
        acc = {32'd0, vup} * {65'd0, wu} + {32'd0, vdn} * {65'd0, wd};
        acc = acc >> 30;
        return (acc[95:64] != 0) ? {64{1'b1}} : acc[63:0];
    endfunction

    function automatic logic [63:0] exercise_value(logic [63:0] spot, logic [63:0] k,
                                                   logic call);
        if (call) return (spot > k) ? spot - k : 64'd0;
        return (k > spot) ? k - spot : 64'd0;
    endfunction

    // Price one option with the current step count.
    function automatic t_quote price_option(t_option o);
        t_quote q;
        int n;
        logic [63:0] grow;
        logic [63:0] v;
        logic [63:0] ex;
        logic [31:0] lf;
        q = '0;
        n = (model_steps > 256) ? 256 : model_steps;
        model_spots[0] = o.lowest_spot;
        for (int i = 1; i <= n; i++) model_spots[i] = scale_q28(model_spots[i-1], o.up_squared);
        for (int i = 0; i <= n; i++)
            model_nodes[i] = exercise_value(model_spots[i], o.strike, o.is_call);
        if (n == 2) begin
            q.l2_dd = model_nodes[0]; q.l2_mid = model_nodes[1]; q.l2_uu = model_nodes[2];
        end
        lf = ONE_Q28;
        for (int s = n - 1; s >= 0; s--) begin
            grow = ({32'd0, lf} * {32'd0, o.up_factor}) >> 28;
            lf = (grow[63:32] != 0) ? 32'hFFFF_FFFF : grow[31:0];
            for (int i = 0; i <= s; i++) begin
                v = discount_pair(model_nodes[i+1], o.weight_up, model_nodes[i], o.weight_down);
                if (o.is_american) begin
                    ex = exercise_value(scale_q28(model_spots[i], lf), o.strike, o.is_call);
                    if (ex > v) v = ex;
                end
                model_nodes[i] = v;
            end
            if (s == 2) begin
                q.l2_dd = model_nodes[0]; q.l2_mid = model_nodes[1]; q.l2_uu = model_nodes[2];
            end
            if (s == 1) begin
                q.l1_down = model_nodes[0]; q.l1_up = model_nodes[1];
            end
        end
        q.price = model_nodes[0];
        if (n >= 2) begin
            q.layers_valid = 1'b1;
        end else begin
            q.l1_down = '0; q.l1_up = '0; q.l2_dd = '0; q.l2_mid = '0; q.l2_uu = '0;
        end
        return q;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] want);
        $display("[%0t] word %0d %s: got %h want %h", $time, words_checked, field, seen, want);
        mismatch_count++;
    endtask

    // Result monitor: sample at the rising edge, compare against the oldest prediction.
    always @(posedge i_clk) begin
        t_quote want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_quotes.size() == 0) begin
                $display("[%0t] result word with nothing predicted", $time);
                mismatch_count++;
            end else begin
                want = pending_quotes.pop_front();
                if (got.price !== want.price) report_mismatch("price", got.price, want.price);
                if (got.l1_down !== want.l1_down)
                    report_mismatch("layer1_down", got.l1_down, want.l1_down);
                if (got.l1_up !== want.l1_up) report_mismatch("layer1_up", got.l1_up, want.l1_up);
                if (got.l2_dd !== want.l2_dd)
                    report_mismatch("layer2_down_down", got.l2_dd, want.l2_dd);
                if (got.l2_mid !== want.l2_mid)
                    report_mismatch("layer2_middle", got.l2_mid, want.l2_mid);
                if (got.l2_uu !== want.l2_uu)
                    report_mismatch("layer2_up_up", got.l2_uu, want.l2_uu);
                if (got.layers_valid !== want.layers_valid)
                    report_mismatch("layers_valid", 64'(got.layers_valid),
                                    64'(want.layers_valid));
            end
            words_checked++;
        end
    end

    // Receiver: hold ready low in reset, then stall at random on the falling edge.
    always @(negedge i_clk) begin
        i_ready <= i_rst_n ? ($urandom_range(99) >= recv_stall_pct) : 1'b0;
    end

    // Send one option word; hold valid and payload until accepted, then predict.
    task automatic send_option(t_option o);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        opt = o;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_quotes = {pending_quotes, price_option(o)};
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every predicted result to drain.
    task automatic drain;
        i_valid = 1'b0;
        while (pending_quotes.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write the step count while the block is idle.
    task automatic write_steps(logic [8:0] steps);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_step_count = steps;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_steps = steps;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Plausible option: spot 20 to 150 in its upper word, u a little above one, weights near one half.
    function automatic t_option sane_option();
        t_option o;
        logic [31:0] u;
        u = ONE_Q28 + $urandom_range(1 << 25);
        o.lowest_spot = {32'd0 + $urandom_range(20, 150), $urandom()};
        o.up_factor   = u;
        o.up_squared  = 32'(({32'd0, u} * {32'd0, u}) >> 28);
        o.weight_up   = 31'(32'h2000_0000 + $urandom_range(1 << 26) - (1 << 25));
        o.weight_down = 31'(32'h3FFF_0000 - o.weight_up);
        o.strike      = {32'd0 + $urandom_range(50, 200), $urandom()};
        o.is_call     = 1'($urandom_range(1));
        o.is_american = 1'($urandom_range(1));
        return o;
    endfunction

    // Raw noise: every bit of every field free.
    function automatic t_option noise_option();
        t_option o;
        o.lowest_spot = rand64();
        o.up_squared  = $urandom();
        o.up_factor   = $urandom();
        o.weight_up   = 31'($urandom());
        o.weight_down = 31'($urandom());
        o.strike      = rand64();
        o.is_call     = 1'($urandom_range(1));
        o.is_american = 1'($urandom_range(1));
        return o;
    endfunction

    // Corners: zero and short lattices, the two-step layer, saturation, odd weights.
    task automatic test_directed;
        t_option o;
        send_idle_pct = 0; recv_stall_pct = 0;
        write_steps(9'd0);
        for (int c = 0; c < 4; c++) begin
            o = sane_option();
            o.is_call = c[0]; o.is_american = c[1];
            send_option(o);
        end
        o = '0; send_option(o);
        o = '1; send_option(o);
        write_steps(9'd1);
        o = sane_option(); o.is_call = 1'b0; o.is_american = 1'b1; send_option(o);
        o = noise_option(); o.lowest_spot = '1; o.up_squared = '1; send_option(o);
        write_steps(9'd2);
        for (int c = 0; c < 4; c++) begin
            o = sane_option();
            o.is_call = c[0]; o.is_american = c[1];
            send_option(o);
        end
        o = sane_option(); o.weight_up = '1; o.weight_down = '1; send_option(o);
        o = sane_option(); o.weight_up = 31'h4000_0000; o.weight_down = '0; send_option(o);
        write_steps(9'd3);
        o = '1; o.is_call = 1'b0; send_option(o);
        o = sane_option(); o.up_factor = '1; o.is_american = 1'b1; o.is_call = 1'b1;
        send_option(o);
        o = sane_option(); o.strike = '0; o.is_call = 1'b1; send_option(o);
        o = sane_option(); o.strike = '1; o.is_call = 1'b0; o.is_american = 1'b1;
        send_option(o);
        o = sane_option(); o.lowest_spot = '0; o.up_squared = '0; send_option(o);
        drain();
    endtask

    // Random options in one idle/stall mix; new step count every few words.
    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct; recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 6 == 0) write_steps(9'($urandom_range(0, 12)));
            if ($urandom_range(99) < 75) send_option(sane_option());
            else send_option(noise_option());
        end
        drain();
    endtask

    // One deep lattice: the widest register value, clamped to the built maximum.
    task automatic test_full_depth;
        t_option o;
        send_idle_pct = 0; recv_stall_pct = 30;
        write_steps(9'd511);
        o = sane_option();
        o.is_call = 1'b0; o.is_american = 1'b1;
        send_option(o);
        drain();
    endtask

    initial begin
        mismatch_count = 0; words_sent = 0; words_checked = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        model_steps = STEP_RESET;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_step_count = '0;
        i_valid = 1'b0; opt = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_phase(0, 0, 24);
        test_random_phase(58, 0, 24);
        test_random_phase(0, 58, 24);
        test_random_phase(32, 32, 24);
        test_full_depth();

        repeat (20) @(negedge i_clk);
        $display("covered %0d option words (%0d results) over step counts 0..12 and 511",
                 words_sent, words_checked);
        $display("idle/stall mixes: none, sender 58%%, receiver 58%%, both 32%%");
        if (mismatch_count == 0 && pending_quotes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
